>>> hw/rtl/art_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the address region table.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int unsigned MaxRegionsDefault = 64;
	localparam logic [31:0] DefaultSpaceEndReset = 32'hC000_0000;
	localparam int unsigned PageBits = 12;

	typedef enum logic [2:0] {
		OP_MAP       = 3'd0,
		OP_UNMAP     = 3'd1,
		OP_FIND_PHYS = 3'd2,
		OP_SPACE_END = 3'd3,
		OP_COUNT     = 3'd4,
		OP_READ      = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERLAP  = 3'd1,
		ST_FULL     = 3'd2,
		ST_SIZE     = 3'd3,
		ST_PHYS     = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] phys_start;
		logic [31:0] virt_start;
		logic [31:0] region_bytes;
		logic [7:0]  usage_flags;
		logic        writable;
		logic [5:0]  entry_index;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_phys;
		logic [31:0] out_virt;
		logic [31:0] out_bytes;
		logic [7:0]  out_usage;
		logic        out_writable;
		logic [6:0]  out_count;
	} rsp_word_t;

	typedef struct packed {
		logic [31:0] virt;
		logic [31:0] phys;
		logic [31:0] bytes;
		logic [7:0]  usage;
		logic        writable;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture command, reset scan state
		logic rd;         // read entry at scan index
		logic eval;       // examine read data
		logic step;       // advance scan index
		logic append;     // write command at count
		logic shift;      // write read data at read index - 1
		logic cnt_dec;
		logic respond;
	} dp_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;  // scan index reached count, or read index out of range
		logic hit;        // key matched, or read entry selected
		logic key_match;  // entry just read carries the key
		logic overlap;
		logic full;
		logic size_bad;
		logic phys_bad;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/art_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// art_datapath
// Entry memory, scan index, counters and result assembly.
// ----------------------------------------------------------------------------
module art_datapath #(
	parameter int unsigned MAX_REGIONS = art_pkg::MaxRegionsDefault,
	localparam int unsigned IW = $clog2(MAX_REGIONS),
	localparam int unsigned CW = $clog2(MAX_REGIONS + 1)
) (
	input  wire                clk,
	input  wire                arst_n,
	input  art_pkg::cmd_word_t cmd,
	input  wire [31:0]         default_space_end,
	input  art_pkg::dp_ctrl_t  ctl,
	output art_pkg::dp_stat_t  stat,
	output art_pkg::rsp_word_t rsp,
	output logic               rsp_valid
);
	import art_pkg::*;

	entry_t           mem [MAX_REGIONS];
	entry_t           rd_q;
	cmd_word_t        cmd_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    rd_idx_q;
	logic             hit_q;
	logic             ovl_q;
	entry_t           sel_q;
	logic             have_q;
	logic [32:0]      hi_new, ehi;
	logic             wr_en;
	logic [IW-1:0]    wr_addr;
	entry_t           wr_data;
	logic [CW-1:0]    ext_idx;
	rsp_word_t        rsp_d;

	assign hi_new  = {1'b0, cmd_q.virt_start} + {1'b0, cmd_q.region_bytes};
	assign ehi     = {1'b0, rd_q.virt} + {1'b0, rd_q.bytes};
	assign ext_idx = CW'(cmd_q.entry_index);

	always_comb begin
		wr_en   = ctl.append | ctl.shift;
		wr_addr = ctl.append ? count_q[IW-1:0] : IW'(rd_idx_q - CW'(1));
		wr_data = ctl.append ?
			entry_t'{virt: cmd_q.virt_start, phys: cmd_q.phys_start,
			         bytes: cmd_q.region_bytes, usage: cmd_q.usage_flags,
			         writable: cmd_q.writable} : rd_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_q <= mem[idx_q[IW-1:0]];
		end
		if (ctl.load) begin
			cmd_q <= cmd;
		end
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.out_count = 7'(ctl.append ? count_q + CW'(1) :
		                     ctl.cnt_dec ? count_q - CW'(1) : count_q);
		case (opcode_t'(cmd_q.opcode))
			OP_MAP: begin
				rsp_d.status = stat.full ? ST_FULL : stat.size_bad ? ST_SIZE :
				               stat.phys_bad ? ST_PHYS : ovl_q ? ST_OVERLAP : ST_OK;
			end
			OP_UNMAP, OP_FIND_PHYS, OP_READ: begin
				if (hit_q) begin
					rsp_d.status       = ST_OK;
					rsp_d.out_phys     = sel_q.phys;
					rsp_d.out_virt     = sel_q.virt;
					rsp_d.out_bytes    = sel_q.bytes;
					rsp_d.out_usage    = sel_q.usage;
					rsp_d.out_writable = sel_q.writable;
				end else begin
					rsp_d.status = ST_NOTFOUND;
				end
			end
			OP_SPACE_END: begin
				rsp_d.status   = ST_OK;
				rsp_d.out_virt = have_q ? sel_q.virt + sel_q.bytes : default_space_end;
			end
			OP_COUNT: rsp_d.status = ST_OK;
			default:  rsp_d.status = ST_NOTFOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			rd_idx_q  <= '0;
			hit_q     <= 1'b0;
			ovl_q     <= 1'b0;
			have_q    <= 1'b0;
			sel_q     <= '0;
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			rsp_valid <= ctl.respond;
			if (ctl.load) begin
				idx_q  <= (opcode_t'(cmd.opcode) == OP_READ) ? CW'(cmd.entry_index) : '0;
				hit_q  <= 1'b0;
				ovl_q  <= 1'b0;
				have_q <= 1'b0;
			end
			if (ctl.rd) begin
				rd_idx_q <= idx_q;
			end
			if (ctl.step) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.eval) begin
				case (opcode_t'(cmd_q.opcode))
					OP_MAP: begin
						if ({1'b0, cmd_q.virt_start} < ehi && {1'b0, rd_q.virt} < hi_new) begin
							ovl_q <= 1'b1;
						end
					end
					OP_UNMAP, OP_FIND_PHYS: begin
						if (!hit_q && rd_q.virt == cmd_q.virt_start) begin
							hit_q <= 1'b1;
							sel_q <= rd_q;
						end
					end
					OP_SPACE_END: begin
						if (!have_q || rd_q.virt > sel_q.virt) begin
							sel_q  <= rd_q;
							have_q <= 1'b1;
						end
					end
					OP_READ: begin
						sel_q <= rd_q;
						hit_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (ctl.append) begin
				count_q <= count_q + CW'(1);
			end
			if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.respond) begin
				rsp <= rsp_d;
			end
		end
	end

	always_comb begin
		stat.scan_done = (idx_q >= count_q) ||
		                 (opcode_t'(cmd_q.opcode) == OP_READ && ext_idx >= count_q);
		stat.hit       = hit_q;
		stat.key_match = rd_q.virt == cmd_q.virt_start;
		stat.overlap   = ovl_q;
		stat.full      = count_q >= CW'(MAX_REGIONS);
		stat.size_bad  = cmd_q.region_bytes[PageBits-1:0] != '0;
		stat.phys_bad  = cmd_q.phys_start[PageBits-1:0] != '0;
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_REGIONS);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("count above depth");

	property p_append_room;
		@(posedge clk) disable iff (!arst_n) ctl.append |-> count_q < CW'(MAX_REGIONS);
	endproperty
	a_append_room: assert property (p_append_room) else $error("append into full table");

	property p_dec_nonzero;
		@(posedge clk) disable iff (!arst_n) ctl.cnt_dec |-> count_q != '0;
	endproperty
	a_dec_nonzero: assert property (p_dec_nonzero) else $error("remove from empty table");

endmodule
`default_nettype wire

>>> hw/rtl/art_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: scan reads and evaluates one entry at a time, then append, shift or answer.
// ----------------------------------------------------------------------------
module art_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire [2:0]         opcode,
	input  art_pkg::dp_stat_t stat,
	output art_pkg::dp_ctrl_t ctl,
	output logic              busy
);
	import art_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_SHRD  = 7'b0001000,
		S_SHWR  = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_CHECK = 7'b1000000
	} state_t;

	state_t   state_q, state_d;
	opcode_t  op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_COUNT;
		end else begin
			state_q <= state_d;
			if (start && !busy) begin
				op_q <= opcode_t'(opcode);
			end
		end
	end

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				// map checks that need no scan go first
				if (op_q == OP_MAP && (stat.full || stat.size_bad || stat.phys_bad)) begin
					state_d = S_FIN;
				end else if (stat.scan_done || op_q == OP_COUNT ||
				             !(op_q == OP_MAP || op_q == OP_UNMAP || op_q == OP_FIND_PHYS ||
				               op_q == OP_SPACE_END || op_q == OP_READ)) begin
					state_d = S_FIN;
				end else begin
					ctl.rd   = 1'b1;
					ctl.step = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_READ: begin
				ctl.rd   = 1'b1;
				ctl.step = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				ctl.eval = 1'b1;
				state_d  = S_READ;
				if (op_q == OP_READ) begin
					state_d = S_FIN;
				end else if ((op_q == OP_UNMAP || op_q == OP_FIND_PHYS) &&
				             (stat.hit || stat.key_match)) begin
					state_d = S_FIN;
				end
				if (stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_SHRD: begin
				if (stat.scan_done) begin
					state_d = S_FIN;
				end else begin
					ctl.rd   = 1'b1;
					ctl.step = 1'b1;
					state_d  = S_SHWR;
				end
			end
			S_SHWR: begin
				ctl.shift = 1'b1;
				state_d   = S_SHRD;
			end
			S_FIN: begin
				if (op_q == OP_UNMAP && stat.hit && !stat.scan_done) begin
					state_d = S_SHRD;
				end else begin
					ctl.respond = 1'b1;
					ctl.append  = op_q == OP_MAP && !stat.full && !stat.size_bad &&
					              !stat.phys_bad && !stat.overlap;
					ctl.cnt_dec = op_q == OP_UNMAP && stat.hit;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	property p_busy_after_start;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy;
	endproperty
	a_busy_after_start: assert property (p_busy_after_start) else $error("start not taken");

	property p_single_respond;
		@(posedge clk) disable iff (!arst_n) ctl.respond |=> !ctl.respond;
	endproperty
	a_single_respond: assert property (p_single_respond) else $error("double answer");

	property p_no_append_and_shift;
		@(posedge clk) disable iff (!arst_n) !(ctl.append && ctl.shift);
	endproperty
	a_no_append_and_shift: assert property (p_no_append_and_shift)
		else $error("write port clash");

endmodule
`default_nettype wire

>>> hw/rtl/address_region_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// address_region_table_core
// Compact table of mapped address regions with map, unmap and lookups.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single answer
// appears on result with done high for one cycle and cannot be held off.
// Count answers without a scan and read fetches only the indexed entry; map,
// find and space end sweep the entries held through the single read port of
// the entry memory, reading then evaluating one entry at a time. Unmap then
// moves each entry above the removed one down a slot to close the gap.
module address_region_table_core #(
	parameter int unsigned MAX_REGIONS = art_pkg::MaxRegionsDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  art_pkg::cmd_word_t  cmd,
	output logic                done,
	output art_pkg::rsp_word_t  result,
	input  wire                 cfg_we,
	input  wire [31:0]          cfg_wdata
);
	import art_pkg::*;

	dp_ctrl_t    ctl;
	dp_stat_t    stat;
	logic [31:0] space_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_end_q <= DefaultSpaceEndReset;
		end else if (cfg_we) begin
			space_end_q <= cfg_wdata;
		end
	end

	art_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (cmd.opcode),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	art_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.default_space_end (space_end_q),
		.ctl               (ctl),
		.stat              (stat),
		.rsp               (result),
		.rsp_valid         (done)
	);

endmodule
`default_nettype wire
